@@ sv/ffa_pkg.sv @@
package ffa_pkg;

	localparam int POOL_BYTES   = 4096;
	localparam int LIST_ENTRIES = 64;
	localparam int HDR_BYTES    = 8;

	localparam int ADDR_W = 12;
	localparam int HDR_AW = $clog2(POOL_BYTES);
	localparam int SIZE_W = HDR_AW + 1;
	localparam int IDX_W  = $clog2(LIST_ENTRIES);
	localparam int CNT_W  = IDX_W + 1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_LIST_FULL = 2'd2,
		ST_BAD_ADDR  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic    load_item;
		logic    clr_step;
		logic    search;
		logic    free_rd;
		logic    free_wr;
		logic    load_out;
		status_t out_status;
	} ffa_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic addr_low;
		logic list_full;
		logic hit;
		logic search_end;
		logic out_busy;
	} ffa_sts_t;

endpackage

@@ sv/ffa_ram.sv @@
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/ffa_dp.sv @@
module ffa_dp import ffa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ffa_cmd_t    cmd,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata,
	output ffa_sts_t    sts
);

	logic              kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [HDR_AW-1:0] base_q;
	logic [SIZE_W-1:0] total_q;
	logic [CNT_W-1:0]  idx_q;
	logic              rd_pend_q;
	logic [CNT_W-1:0]  count_q;
	logic [HDR_AW-1:0] clr_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_status_q;

	logic [2*SIZE_W-1:0] ent_wdata;
	logic [2*SIZE_W-1:0] ent_rdata;
	logic [IDX_W-1:0]    ent_waddr;
	logic                ent_we;
	logic [SIZE_W-1:0]   ent_off;
	logic [SIZE_W-1:0]   ent_size;
	logic                hdr_we;
	logic [HDR_AW-1:0]   hdr_waddr;
	logic [SIZE_W-1:0]   hdr_wdata;
	logic [SIZE_W-1:0]   hdr_rdata;
	logic                hit;
	logic                search_end;
	logic                issue;
	logic                take_hit;

	assign ent_off  = ent_rdata[2*SIZE_W-1:SIZE_W];
	assign ent_size = ent_rdata[SIZE_W-1:0];

	assign hit        = rd_pend_q && (ent_size >= total_q);
	assign search_end = idx_q >= count_q;
	assign issue      = cmd.search && !hit && !search_end;
	assign take_hit   = cmd.search && hit;

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = '0;
		if (cmd.clr_step && clr_q == '0) begin
			ent_we    = 1'b1;
			ent_wdata = {SIZE_W'(0), SIZE_W'(POOL_BYTES)};
		end else if (take_hit) begin
			ent_we    = 1'b1;
			ent_waddr = IDX_W'(idx_q - CNT_W'(1));
			ent_wdata = {ent_off + total_q, ent_size - total_q};
		end else if (cmd.free_wr) begin
			ent_we    = 1'b1;
			ent_waddr = count_q[IDX_W-1:0];
			ent_wdata = {SIZE_W'(base_q), hdr_rdata};
		end
	end

	always_comb begin
		hdr_we    = 1'b0;
		hdr_waddr = clr_q;
		hdr_wdata = '0;
		if (cmd.clr_step) begin
			hdr_we = 1'b1;
		end else if (take_hit && !ent_off[SIZE_W-1]) begin
			hdr_we    = 1'b1;
			hdr_waddr = ent_off[HDR_AW-1:0];
			hdr_wdata = total_q;
		end
	end

	ffa_ram #(
		.WIDTH(2*SIZE_W),
		.DEPTH(LIST_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re   (issue),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ent_rdata)
	);

	ffa_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(POOL_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (hdr_we),
		.waddr(hdr_waddr),
		.wdata(hdr_wdata),
		.re   (cmd.free_rd),
		.raddr(base_q),
		.rdata(hdr_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= s_tuser;
			addr_q  <= s_tdata[23:12];
			base_q  <= HDR_AW'(s_tdata[23:12] - ADDR_W'(HDR_BYTES));
			total_q <= SIZE_W'(s_tdata[11:0]) + SIZE_W'(HDR_BYTES);
		end
		if (take_hit) begin
			res_addr_q <= ADDR_W'(ent_off + SIZE_W'(HDR_BYTES));
		end
		if (cmd.load_out) begin
			out_status_q <= cmd.out_status;
			out_addr_q   <= (cmd.out_status == ST_OK && kind_q == KIND_ALLOC) ?
				res_addr_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			count_q     <= CNT_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			if (cmd.load_item) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.free_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + HDR_AW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last   = clr_q == HDR_AW'(POOL_BYTES - 1);
	assign sts.is_free    = kind_q == KIND_FREE;
	assign sts.addr_low   = addr_q < ADDR_W'(HDR_BYTES);
	assign sts.list_full  = count_q >= CNT_W'(LIST_ENTRIES);
	assign sts.hit        = hit;
	assign sts.search_end = search_end;
	assign sts.out_busy   = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_status_q, out_addr_q};

endmodule

@@ sv/ffa_ctrl.sv @@
module ffa_ctrl import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ffa_sts_t sts,
	output ffa_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_FREE_RD,
		S_FREE_WR,
		S_FINISH
	} state_t;

	state_t  state_q;
	status_t fin_status_q;

	assign s_tready = state_q == S_IDLE;

	always_comb begin
		cmd            = '0;
		cmd.out_status = fin_status_q;
		unique case (state_q)
			S_CLEAR:   cmd.clr_step  = 1'b1;
			S_IDLE:    cmd.load_item = s_tvalid;
			S_DECODE:  cmd.search    = 1'b0;
			S_SEARCH:  cmd.search    = 1'b1;
			S_FREE_RD: cmd.free_rd   = 1'b1;
			S_FREE_WR: cmd.free_wr   = 1'b1;
			S_FINISH:  cmd.load_out  = !sts.out_busy;
			default:   cmd.search    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			fin_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (!sts.is_free) begin
						state_q <= S_SEARCH;
					end else if (sts.addr_low) begin
						fin_status_q <= ST_BAD_ADDR;
						state_q      <= S_FINISH;
					end else if (sts.list_full) begin
						fin_status_q <= ST_LIST_FULL;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_FREE_RD;
					end
				end
				S_SEARCH: begin
					if (sts.hit) begin
						fin_status_q <= ST_OK;
						state_q      <= S_FINISH;
					end else if (sts.search_end) begin
						fin_status_q <= ST_NO_FIT;
						state_q      <= S_FINISH;
					end
				end
				S_FREE_RD: state_q <= S_FREE_WR;
				S_FREE_WR: begin
					fin_status_q <= ST_OK;
					state_q      <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/first_fit_free_list_allocator.sv @@
// first-fit allocator over a 4096-byte pool with a 64-entry free list
// input beats: s_tuser is the kind (0 allocate, 1 free), s_tdata carries
// request_size and block_address; one result beat per input beat on m_*
// allocate: scans the free list one entry per cycle through the entry ram,
// takes the first entry large enough and writes its header in the same cycle
// an allocate stops at the first fitting entry k (k from 1 to the list count);
// a miss scans every entry of the list and answers with the no-fit status
// free: one header ram read and one entry ram write
// address-below-8 and list-full frees answer straight from decode, with no ram access
// one item is in work at a time; the next beat is accepted as soon as the
// result sits in the output register, even while m_tready is low
// a stalled receiver holds the result in the output register and the block
// waits before writing the next result over it
// after reset the header ram is swept to zero, one entry a cycle, and the
// list is set to one entry covering the pool: s_tready stays low until the
// sweep is done
module first_fit_free_list_allocator import ffa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // request_size [11:0], block_address [23:12]
	input  logic        s_tuser,   // kind [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // user_address [11:0], status [13:12], zero [15:14]
);

	ffa_cmd_t cmd;
	ffa_sts_t sts;

	ffa_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.sts     (sts)
	);

	ffa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[11:0] != 12'd0 |-> m_tdata[13:12] == ST_OK)
		else $error("nonzero user address on a failed beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("result written over a stalled beat");
`endif

endmodule
